/* rtl/gad_pkg.sv */
`default_nettype none

package gad_pkg;

  localparam int NUM_PADS = 4;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [14:0] LEFT_DZ_RST    = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST   = 15'd8689;
  localparam logic [7:0]  TRIG_THR_RST   = 8'd30;
  localparam logic [15:0] STICK_STEP_RST = 16'd1024;
  localparam logic [7:0]  TRIG_STEP_RST  = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_DZ    = 3'd0,
    REG_RIGHT_DZ   = 3'd1,
    REG_TRIG_THR   = 3'd2,
    REG_STICK_STEP = 3'd3,
    REG_TRIG_STEP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         pad_index;
    logic               read_ok;
    logic [31:0]        packet_number;
    logic [15:0]        button_bits;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } poll_t;

  typedef struct packed {
    logic        activity;
    logic        state_changed;
    logic        connected;
    logic [15:0] reported_buttons;
  } result_t;

  typedef struct packed {
    logic [14:0] left_deadzone;
    logic [14:0] right_deadzone;
    logic [7:0]  trigger_threshold;
    logic [15:0] stick_step;
    logic [7:0]  trigger_step;
  } cfg_t;

  // Stored sample of one pad slot
  typedef struct packed {
    logic [31:0]        packet;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } pad_rec_t;

  typedef struct packed {
    logic     hit;
    logic     valid;
    pad_rec_t rec;
  } lookup_t;

  typedef struct packed {
    logic     en;
    logic     clear;
    pad_rec_t rec;
  } store_wr_t;

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = 17'(v);
    return (w < 0) ? 17'(-w) : 17'(w);
  endfunction

  function automatic logic axis_moved(input logic signed [15:0] now,
                                      input logic signed [15:0] prev,
                                      input logic [14:0] dz,
                                      input logic [15:0] step);
    logic signed [16:0] d;
    logic [16:0]        ad;
    d  = 17'(now) - 17'(prev);
    ad = (d < 0) ? 17'(-d) : 17'(d);
    return (ad >= {1'b0, step}) &&
           ((mag16(now) > {2'b0, dz}) || (mag16(prev) > {2'b0, dz}));
  endfunction

  function automatic logic trig_moved(input logic [7:0] now,
                                      input logic [7:0] prev,
                                      input logic [7:0] thr,
                                      input logic [7:0] step);
    logic [7:0] d;
    d = (now > prev) ? (now - prev) : (prev - now);
    return (d >= step) && ((now > thr) || (prev > thr));
  endfunction

endpackage

`default_nettype wire

/* rtl/gad_if.sv */
`default_nettype none

interface gad_in_if;
  logic          valid;
  logic          ready;
  gad_pkg::poll_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface gad_out_if;
  logic            valid;
  logic            ready;
  gad_pkg::result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* rtl/gad_cfg_regs.sv */
`default_nettype none

module gad_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [gad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gad_pkg::CFG_DATA_W-1:0] cfg_data,
  output gad_pkg::cfg_t                       cfg
);
  import gad_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_deadzone     <= LEFT_DZ_RST;
      cfg.right_deadzone    <= RIGHT_DZ_RST;
      cfg.trigger_threshold <= TRIG_THR_RST;
      cfg.stick_step        <= STICK_STEP_RST;
      cfg.trigger_step      <= TRIG_STEP_RST;
    end else if (cfg_we) begin
      // keep the low bits; unknown indexes drop the write
      case (cfg_index)
        REG_LEFT_DZ:    cfg.left_deadzone     <= cfg_data[14:0];
        REG_RIGHT_DZ:   cfg.right_deadzone    <= cfg_data[14:0];
        REG_TRIG_THR:   cfg.trigger_threshold <= cfg_data[7:0];
        REG_STICK_STEP: cfg.stick_step        <= cfg_data[15:0];
        REG_TRIG_STEP:  cfg.trigger_step      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gad_pad_store.sv */
`default_nettype none

module gad_pad_store (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] pad,
  input  wire gad_pkg::store_wr_t wr,
  output gad_pkg::lookup_t   lookup
);
  import gad_pkg::*;

  logic [NUM_PADS-1:0] valid;
  logic [NUM_PADS-1:0] sel;
  pad_rec_t            recs [NUM_PADS];

  always_comb begin
    lookup = '0;
    for (int i = 0; i < NUM_PADS; i++) begin
      sel[i] = (int'(pad) == i);
      if (sel[i]) begin
        lookup.hit   = 1'b1;
        lookup.valid = valid[i];
        lookup.rec   = recs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        if (sel[i]) valid[i] <= !wr.clear;
      end
    end
  end

  // sample contents only matter while the slot is valid
  always_ff @(posedge clk) begin
    if (wr.en && !wr.clear) begin
      for (int i = 0; i < NUM_PADS; i++) begin
        if (sel[i]) recs[i] <= wr.rec;
      end
    end
  end

  a_store_sets: assert property (@(posedge clk) disable iff (rst)
    wr.en && !wr.clear && lookup.hit |=> (valid & $past(sel)) != '0)
    else $error("stored sample did not mark slot valid");

  a_clear_drops: assert property (@(posedge clk) disable iff (rst)
    wr.en && wr.clear |=> (valid & $past(sel)) == '0)
    else $error("failed read did not clear slot");

endmodule

`default_nettype wire

/* rtl/gad_eval.sv */
`default_nettype none

module gad_eval (
  input  wire gad_pkg::poll_t   poll,
  input  wire gad_pkg::lookup_t lookup,
  input  wire gad_pkg::cfg_t    cfg,
  output gad_pkg::result_t   res,
  output gad_pkg::store_wr_t wr
);
  import gad_pkg::*;

  logic new_press;
  logic stick_act;
  logic trig_act;
  logic fresh;

  always_comb begin
    new_press = (poll.button_bits & ~lookup.rec.buttons) != '0;
    stick_act =
      axis_moved(poll.left_x, lookup.rec.left_x, cfg.left_deadzone, cfg.stick_step) ||
      axis_moved(poll.left_y, lookup.rec.left_y, cfg.left_deadzone, cfg.stick_step) ||
      axis_moved(poll.right_x, lookup.rec.right_x, cfg.right_deadzone, cfg.stick_step) ||
      axis_moved(poll.right_y, lookup.rec.right_y, cfg.right_deadzone, cfg.stick_step);
    trig_act =
      trig_moved(poll.left_trigger, lookup.rec.left_trigger,
                 cfg.trigger_threshold, cfg.trigger_step) ||
      trig_moved(poll.right_trigger, lookup.rec.right_trigger,
                 cfg.trigger_threshold, cfg.trigger_step);

    fresh = !lookup.valid || (lookup.rec.packet != poll.packet_number);

    wr.rec.packet        = poll.packet_number;
    wr.rec.buttons       = poll.button_bits;
    wr.rec.left_x        = poll.left_x;
    wr.rec.left_y        = poll.left_y;
    wr.rec.right_x       = poll.right_x;
    wr.rec.right_y       = poll.right_y;
    wr.rec.left_trigger  = poll.left_trigger;
    wr.rec.right_trigger = poll.right_trigger;
    wr.clear             = !poll.read_ok;
    wr.en                = 1'b0;
    res                  = '0;

    if (lookup.hit) begin
      if (!poll.read_ok) begin
        wr.en             = lookup.valid;
        res.state_changed = lookup.valid;
      end else if (fresh) begin
        wr.en                = 1'b1;
        res.state_changed    = 1'b1;
        res.connected        = 1'b1;
        res.reported_buttons = poll.button_bits;
        res.activity         = lookup.valid && (new_press || stick_act || trig_act);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gamepad_activity_detector.sv */
// Gamepad activity detector.
// A poll word enters on the poll channel (valid/ready); exactly one result
// word leaves on the result channel for every poll, in order. The block keeps
// the last good sample and a valid bit for each pad slot and flags activity
// when a new packet shows a fresh button press, a stick move outside its
// deadzone or a trigger move above its threshold.
// A poll passes the input register, then one pass of compare logic into the
// result register.
// Throughput: one poll per cycle while results are taken, back to back, also
// on the same pad; the slot state is written at the same edge that loads the
// result register, so the next poll sees it.
// Stall: when the result is not taken, the input register fills and holds;
// poll.ready drops only when both registers are full.
// Reset (rst, synchronous): empties both registers, marks every slot empty
// and loads the register defaults. The user must write the registers (cfg_we,
// cfg_index, cfg_data) only while the block is idle; it is not enforced.
`default_nettype none

module gamepad_activity_detector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  gad_in_if.sink                              poll,
  gad_out_if.source                           result,
  input  wire logic                           cfg_we,
  input  wire logic [gad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gad_pkg::*;

  cfg_t      cfg;
  poll_t     in_q;
  logic      in_vld;
  result_t   out_q;
  logic      out_vld;
  logic      move;
  lookup_t   lookup;
  result_t   res;
  store_wr_t wr;
  store_wr_t wr_gated;

  assign move        = in_vld && (!out_vld || result.ready);
  assign poll.ready  = !in_vld || move;
  assign result.valid = out_vld;
  assign result.item  = out_q;

  gad_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gad_pad_store u_store (
    .clk    (clk),
    .rst    (rst),
    .pad    (in_q.pad_index),
    .wr     (wr_gated),
    .lookup (lookup)
  );

  gad_eval u_eval (
    .poll   (in_q),
    .lookup (lookup),
    .cfg    (cfg),
    .res    (res),
    .wr     (wr)
  );

  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr.en && move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (poll.valid && poll.ready) in_vld <= 1'b1;
      else if (move)                in_vld <= 1'b0;
      if (move)              out_vld <= 1'b1;
      else if (result.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) in_q <= poll.item;
    if (move) out_q <= res;
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && !move |=> in_vld && $stable(in_q))
    else $error("held poll word lost while result stalled");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_q.state_changed |->
      !out_q.connected && !out_q.activity && out_q.reported_buttons == '0)
    else $error("result fields set without a state change");

  a_write_moves: assert property (@(posedge clk) disable iff (rst)
    wr_gated.en |=> out_vld && out_q.state_changed)
    else $error("slot written without a changed result");

endmodule

`default_nettype wire
